// File: hw/rtl/tpts_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpts_pkg
// Shared types and constants of the two-level preemptive thread scheduler.
// ---------------------------------------------------------------------------
package tpts_pkg;

   // Operation codes carried by req_op.
   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_EXIT    = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;
   localparam logic [1:0] OP_SET_PRI = 2'd3;

   localparam int OP_W       = 2;
   localparam int QUANTUM_W  = 8;
   localparam int OUT_SLOT_W = 4;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd10;

   // The free-slot search looks at this many slots per clock cycle.
   localparam int SCAN_W     = 16;
   localparam int SCAN_IDX_W = 4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan_step;
      logic exec;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_scan;
      logic scan_end;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/tpts_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpts_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tpts_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/tpts_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpts_ctrl
// Sequencer: accepts a transaction, runs the free-slot search for a create
// unless halted, applies the update, hands the result to the output register.
// ---------------------------------------------------------------------------
module tpts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tpts_pkg::sts_type sts,
   output tpts_pkg::cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.needs_scan ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/tpts_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpts_dpath
// Scheduler state: slot flags, two ready queues, running thread, quantum
// counter, free-slot search and the result register.
// ---------------------------------------------------------------------------
module tpts_dpath #(
   parameter int THREAD_SLOTS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tpts_pkg::cmd_type                   cmd,
   output tpts_pkg::sts_type                        sts,
   input  wire logic [tpts_pkg::OP_W-1:0]           req_op,
   input  wire logic                                req_priority_req,
   input  wire logic                                csr_wr_en,
   input  wire logic [tpts_pkg::QUANTUM_W-1:0]      csr_wr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [tpts_pkg::OUT_SLOT_W-1:0]     rsp_running_thread,
   output logic                                     rsp_running_priority,
   output logic                                     rsp_switched,
   output logic      [tpts_pkg::OUT_SLOT_W-1:0]     rsp_created_thread,
   output logic                                     rsp_create_failed,
   output logic                                     rsp_halted
);

   localparam int SLOT_BITS = $clog2(THREAD_SLOTS);
   localparam int CNT_BITS  = $clog2(THREAD_SLOTS + 1);
   localparam int SUM_W     = SLOT_BITS + 2;
   localparam int GROUPS    = (THREAD_SLOTS + tpts_pkg::SCAN_W - 1) / tpts_pkg::SCAN_W;
   localparam int GRP_BITS  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD_W     = GROUPS * tpts_pkg::SCAN_W;
   localparam int HIT_W     = GRP_BITS + tpts_pkg::SCAN_IDX_W;
   localparam int EXT_W     = SLOT_BITS + tpts_pkg::OUT_SLOT_W;
   localparam int QW        = tpts_pkg::QUANTUM_W;

   // Architectural state.
   logic [THREAD_SLOTS-1:0] in_use_ff,  in_use_in;
   logic [THREAD_SLOTS-1:0] prio_ff,    prio_in;
   logic [SLOT_BITS-1:0]    current_ff, current_in;
   logic [QW-1:0]           ticks_ff,   ticks_in;
   logic                    halted_ff,  halted_in;
   logic [QW-1:0]           quantum_ff;
   logic [SLOT_BITS-1:0]    hi_head_ff, hi_head_in;
   logic [CNT_BITS-1:0]     hi_cnt_ff,  hi_cnt_in;
   logic [SLOT_BITS-1:0]    lo_head_ff, lo_head_in;
   logic [CNT_BITS-1:0]     lo_cnt_ff,  lo_cnt_in;

   // Captured transaction and per-item results.
   logic [tpts_pkg::OP_W-1:0] op_ff;
   logic                      pri_req_ff;
   logic [GRP_BITS-1:0]       grp_ff;
   logic                      found_ff;
   logic [SLOT_BITS-1:0]      free_slot_ff;
   logic                      sw_ff,      sw_in;
   logic [SLOT_BITS-1:0]      created_ff, created_in;
   logic                      failed_ff,  failed_in;

   // Result register.
   logic                             rsp_valid_ff;
   logic [tpts_pkg::OUT_SLOT_W-1:0]  rsp_thread_ff;
   logic                             rsp_pri_ff;
   logic                             rsp_sw_ff;
   logic [tpts_pkg::OUT_SLOT_W-1:0]  rsp_created_ff;
   logic                             rsp_failed_ff;
   logic                             rsp_halted_ff;

   // Queue memories.
   logic                 hi_wr_en, lo_wr_en;
   logic [SLOT_BITS-1:0] hi_wr_data, lo_wr_data;
   logic [SLOT_BITS-1:0] hi_tail, lo_tail;
   logic [SLOT_BITS-1:0] hi_rd_data, lo_rd_data;

   tpts_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (THREAD_SLOTS)
   ) u_hi_ram (
      .clock   (clock),
      .wr_en   (hi_wr_en),
      .wr_addr (hi_tail),
      .wr_data (hi_wr_data),
      .rd_addr (hi_head_ff),
      .rd_data (hi_rd_data)
   );

   tpts_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (THREAD_SLOTS)
   ) u_lo_ram (
      .clock   (clock),
      .wr_en   (lo_wr_en),
      .wr_addr (lo_tail),
      .wr_data (lo_wr_data),
      .rd_addr (lo_head_ff),
      .rd_data (lo_rd_data)
   );

   // Tail = (head + count) mod slots; the sum stays below twice the depth.
   logic [SUM_W-1:0] hi_sum, lo_sum;
   assign hi_sum  = SUM_W'(hi_head_ff) + SUM_W'(hi_cnt_ff);
   assign lo_sum  = SUM_W'(lo_head_ff) + SUM_W'(lo_cnt_ff);
   assign hi_tail = (hi_sum >= SUM_W'(THREAD_SLOTS)) ?
                    SLOT_BITS'(hi_sum - SUM_W'(THREAD_SLOTS)) : SLOT_BITS'(hi_sum);
   assign lo_tail = (lo_sum >= SUM_W'(THREAD_SLOTS)) ?
                    SLOT_BITS'(lo_sum - SUM_W'(THREAD_SLOTS)) : SLOT_BITS'(lo_sum);

   // Free-slot search, one group of slots per cycle.
   logic [PAD_W-1:0]              in_use_pad;
   logic [tpts_pkg::SCAN_W-1:0]   grp_bits;
   logic [tpts_pkg::SCAN_IDX_W-1:0] grp_pe;
   logic                          grp_hit;
   logic [HIT_W-1:0]              hit_slot;

   always_comb begin
      in_use_pad = '1;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
         in_use_pad[i] = in_use_ff[i];
      end
   end

   assign grp_bits = in_use_pad[grp_ff*tpts_pkg::SCAN_W +: tpts_pkg::SCAN_W];
   assign grp_hit  = ~&grp_bits;

   always_comb begin
      grp_pe = '0;
      for (int i = tpts_pkg::SCAN_W - 1; i >= 0; i--) begin
         if (!grp_bits[i]) begin
            grp_pe = tpts_pkg::SCAN_IDX_W'(i);
         end
      end
   end

   assign hit_slot = {grp_ff, grp_pe};

   assign sts.needs_scan = (req_op == tpts_pkg::OP_CREATE) && !halted_ff;
   assign sts.scan_end   = grp_hit || (grp_ff == GRP_BITS'(GROUPS - 1));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Item update.
   logic cur_prio, hi_ne, lo_ne, pick_ok;
   logic [SLOT_BITS-1:0] pick_slot;
   logic hi_pop, lo_pop, hi_push, lo_push;

   assign cur_prio  = prio_ff[current_ff];
   assign hi_ne     = (hi_cnt_ff != '0);
   assign lo_ne     = (lo_cnt_ff != '0);
   assign pick_ok   = hi_ne || lo_ne;
   assign pick_slot = hi_ne ? hi_rd_data : lo_rd_data;

   always_comb begin
      in_use_in  = in_use_ff;
      prio_in    = prio_ff;
      current_in = current_ff;
      ticks_in   = ticks_ff;
      halted_in  = halted_ff;
      sw_in      = 1'b0;
      created_in = '0;
      failed_in  = 1'b0;
      hi_pop     = 1'b0;
      lo_pop     = 1'b0;
      hi_push    = 1'b0;
      lo_push    = 1'b0;
      hi_wr_data = free_slot_ff;
      lo_wr_data = free_slot_ff;

      if (halted_ff) begin
         failed_in = (op_ff == tpts_pkg::OP_CREATE);
      end else begin
         case (op_ff)
            tpts_pkg::OP_CREATE: begin
               if (!found_ff) begin
                  failed_in = 1'b1;
               end else begin
                  in_use_in[free_slot_ff] = 1'b1;
                  prio_in[free_slot_ff]   = pri_req_ff;
                  created_in              = free_slot_ff;
                  if (pri_req_ff) begin
                     if (cur_prio) begin
                        hi_push = 1'b1;
                     end else begin
                        // Preemption: the running low thread goes to the low tail.
                        lo_push    = 1'b1;
                        lo_wr_data = current_ff;
                        current_in = free_slot_ff;
                        ticks_in   = quantum_ff;
                        sw_in      = 1'b1;
                     end
                  end else begin
                     lo_push = 1'b1;
                  end
               end
            end
            tpts_pkg::OP_EXIT: begin
               in_use_in[current_ff] = 1'b0;
               if (pick_ok) begin
                  hi_pop     = hi_ne;
                  lo_pop     = !hi_ne;
                  current_in = pick_slot;
                  ticks_in   = quantum_ff;
                  sw_in      = 1'b1;
               end else begin
                  halted_in = 1'b1;
               end
            end
            tpts_pkg::OP_TICK: begin
               if (!cur_prio) begin
                  if (ticks_ff <= QW'(1)) begin
                     ticks_in = quantum_ff;
                     if (pick_ok) begin
                        hi_pop     = hi_ne;
                        lo_pop     = !hi_ne;
                        lo_push    = 1'b1;
                        lo_wr_data = current_ff;
                        current_in = pick_slot;
                        sw_in      = 1'b1;
                     end
                  end else begin
                     ticks_in = ticks_ff - QW'(1);
                  end
               end
            end
            tpts_pkg::OP_SET_PRI: begin
               prio_in[current_ff] = pri_req_ff;
            end
            default: begin
               failed_in = 1'b0;
            end
         endcase
      end
   end

   // A push into a full queue is dropped.
   assign hi_wr_en = cmd.exec && hi_push && (hi_cnt_ff != CNT_BITS'(THREAD_SLOTS));
   assign lo_wr_en = cmd.exec && lo_push && (lo_cnt_ff != CNT_BITS'(THREAD_SLOTS));

   always_comb begin
      hi_head_in = hi_head_ff;
      lo_head_in = lo_head_ff;
      hi_cnt_in  = hi_cnt_ff;
      lo_cnt_in  = lo_cnt_ff;
      if (hi_pop) begin
         hi_head_in = (hi_head_ff == SLOT_BITS'(THREAD_SLOTS - 1)) ? '0 :
                      hi_head_ff + SLOT_BITS'(1);
      end
      if (lo_pop) begin
         lo_head_in = (lo_head_ff == SLOT_BITS'(THREAD_SLOTS - 1)) ? '0 :
                      lo_head_ff + SLOT_BITS'(1);
      end
      case ({hi_wr_en, hi_pop})
         2'b10:   hi_cnt_in = hi_cnt_ff + CNT_BITS'(1);
         2'b01:   hi_cnt_in = hi_cnt_ff - CNT_BITS'(1);
         default: hi_cnt_in = hi_cnt_ff;
      endcase
      case ({lo_wr_en, lo_pop})
         2'b10:   lo_cnt_in = lo_cnt_ff + CNT_BITS'(1);
         2'b01:   lo_cnt_in = lo_cnt_ff - CNT_BITS'(1);
         default: lo_cnt_in = lo_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= THREAD_SLOTS'(1);
         prio_ff    <= '0;
         current_ff <= '0;
         ticks_ff   <= tpts_pkg::QUANTUM_RESET;
         halted_ff  <= 1'b0;
         quantum_ff <= tpts_pkg::QUANTUM_RESET;
         hi_head_ff <= '0;
         hi_cnt_ff  <= '0;
         lo_head_ff <= '0;
         lo_cnt_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
         if (cmd.exec) begin
            in_use_ff  <= in_use_in;
            prio_ff    <= prio_in;
            current_ff <= current_in;
            ticks_ff   <= ticks_in;
            halted_ff  <= halted_in;
            hi_head_ff <= hi_head_in;
            hi_cnt_ff  <= hi_cnt_in;
            lo_head_ff <= lo_head_in;
            lo_cnt_ff  <= lo_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         pri_req_ff <= req_priority_req;
         grp_ff     <= '0;
         found_ff   <= 1'b0;
      end
      if (cmd.scan_step) begin
         grp_ff <= grp_ff + GRP_BITS'(1);
         if (grp_hit) begin
            found_ff     <= 1'b1;
            free_slot_ff <= SLOT_BITS'(hit_slot);
         end
      end
      if (cmd.exec) begin
         sw_ff      <= sw_in;
         created_ff <= created_in;
         failed_ff  <= failed_in;
      end
   end

   // Result register; it reflects the state after the item's update.
   logic [EXT_W-1:0] cur_ext, created_ext;
   assign cur_ext     = EXT_W'(current_ff);
   assign created_ext = EXT_W'(created_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_thread_ff  <= cur_ext[tpts_pkg::OUT_SLOT_W-1:0];
         rsp_pri_ff     <= prio_ff[current_ff];
         rsp_sw_ff      <= sw_ff;
         rsp_created_ff <= created_ext[tpts_pkg::OUT_SLOT_W-1:0];
         rsp_failed_ff  <= failed_ff;
         rsp_halted_ff  <= halted_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_running_thread   = rsp_thread_ff;
   assign rsp_running_priority = rsp_pri_ff;
   assign rsp_switched         = rsp_sw_ff;
   assign rsp_created_thread   = rsp_created_ff;
   assign rsp_create_failed    = rsp_failed_ff;
   assign rsp_halted           = rsp_halted_ff;

endmodule
`default_nettype wire

// File: hw/rtl/two_level_preemptive_thread_scheduler_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_level_preemptive_thread_scheduler_core
// Two-level (high / low) preemptive thread scheduler over a fixed set of
// thread slots, with round-robin time slicing of low-priority threads.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Content
//   req_      in         req_valid / req_ready  op, priority_req
//   rsp_      out        rsp_valid / rsp_ready  running thread, flags
//   csr_      in         csr_wr_en (no wait)    quantum length in ticks
//
// A transaction that is not a create is captured when it is accepted, applied
// in the exec state and then moved into the result register once that register
// is free, that is empty or being read through rsp_ready. A create first
// searches for a free slot, one group of 16 slots per cycle until a free one is
// seen or the last group is searched; a create after the halt skips the search.
// One transaction is in work at a time; the next one is accepted as soon as
// the current one has moved into the result register, even while that
// result still waits for rsp_ready.
// After reset slot 0 runs, both ready queues are empty and the quantum is 10.
//
module two_level_preemptive_thread_scheduler_core #(
   parameter int THREAD_SLOTS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tpts_pkg::OP_W-1:0]       req_op,
   input  wire logic                            req_priority_req,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [tpts_pkg::OUT_SLOT_W-1:0] rsp_running_thread,
   output logic                                 rsp_running_priority,
   output logic                                 rsp_switched,
   output logic      [tpts_pkg::OUT_SLOT_W-1:0] rsp_created_thread,
   output logic                                 rsp_create_failed,
   output logic                                 rsp_halted,
   input  wire logic                            csr_wr_en,
   input  wire logic [tpts_pkg::QUANTUM_W-1:0]  csr_wr_data
);

   // The controller sequences each transaction; the datapath owns all scheduler state.
   tpts_pkg::cmd_type cmd;
   tpts_pkg::sts_type sts;

   tpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The quantum register is written directly; a new value takes effect at
   // the next reload of the tick counter.
   tpts_dpath #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_op               (req_op),
      .req_priority_req     (req_priority_req),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_running_thread   (rsp_running_thread),
      .rsp_running_priority (rsp_running_priority),
      .rsp_switched         (rsp_switched),
      .rsp_created_thread   (rsp_created_thread),
      .rsp_create_failed    (rsp_create_failed),
      .rsp_halted           (rsp_halted)
   );

endmodule
`default_nettype wire
